// ----- src/shfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package shfp_pkg;

    // djb2 starting value; the hash is kept modulo 2^64 or narrower.
    localparam logic [63:0] SEED_VALUE = 64'd5381;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // What the back part has to do with one queued request.
    typedef struct packed {
        logic fold;   // fold the hash into the counters
        logic doc;    // emit the fingerprint, then clear the counters
    } t_job_flags;

    localparam int FLAG_BITS = $bits(t_job_flags);

endpackage

`default_nettype wire

// ----- src/shfp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shfp_queue
    import shfp_pkg::*;
#(
    parameter int WIDTH = 66
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_head,
    output logic                  o_empty
);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/shfp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shfp_front
    import shfp_pkg::*;
#(
    parameter int HASH_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_byte_valid,
    input  wire logic                 i_token_end,
    input  wire logic                 i_doc_end,
    output logic                      o_push,
    output t_job_flags                o_push_flags,
    output logic [HASH_BITS-1:0]      o_push_hash,
    input  wire logic                 i_queue_full
);

    localparam logic [HASH_BITS-1:0] SEED = SEED_VALUE[HASH_BITS-1:0];

    logic [HASH_BITS-1:0] r_hash;
    logic [HASH_BITS-1:0] n_hash;
    logic [63:0]          w_byte_ext;
    logic                 w_accept;

    // Only the low hash bits feed the counters, and the low bits of
    // h*33+c depend on nothing above them, so the hash is kept that narrow.
    assign w_byte_ext = {{56{i_data_byte[7]}}, i_data_byte};
    assign n_hash     = i_byte_valid
                      ? (r_hash << 5) + r_hash + w_byte_ext[HASH_BITS-1:0]
                      : r_hash;

    assign o_ready            = !i_queue_full;
    assign w_accept           = i_valid && o_ready;
    assign o_push             = w_accept && (i_token_end || i_doc_end);
    assign o_push_flags.fold  = i_token_end;
    assign o_push_flags.doc   = i_doc_end;
    assign o_push_hash        = n_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= SEED;
        end else if (w_accept) begin
            if (i_token_end || i_doc_end) begin
                r_hash <= SEED;
            end else begin
                r_hash <= n_hash;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/shfp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shfp_back
    import shfp_pkg::*;
#(
    parameter int HASH_BITS  = 64,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    input  wire t_job_flags           i_flags,
    input  wire logic [HASH_BITS-1:0] i_hash,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [63:0]               o_fingerprint
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [COUNT_BITS-1:0] r_cnt [HASH_BITS];
    logic [COUNT_BITS-1:0] n_cnt [HASH_BITS];
    logic [63:0]           w_fp;
    logic                  r_out_valid;
    logic [63:0]           r_out_fp;

    // A document end must wait for the output register to be free.
    assign o_pop = !i_empty && (!i_flags.doc || !r_out_valid || i_ready);

    genvar k;
    generate
        for (k = 0; k < HASH_BITS; k++) begin : g_lane
            always_comb begin
                n_cnt[k] = r_cnt[k];
                if (i_flags.fold) begin
                    if (i_hash[k]) begin
                        if (r_cnt[k] != CNT_MAX) begin
                            n_cnt[k] = r_cnt[k] + COUNT_BITS'(1);
                        end
                    end else begin
                        if (r_cnt[k] != CNT_MIN) begin
                            n_cnt[k] = r_cnt[k] - COUNT_BITS'(1);
                        end
                    end
                end
            end

            assign w_fp[k] = !n_cnt[k][COUNT_BITS-1] && (n_cnt[k] != '0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt[k] <= '0;
                end else if (o_pop) begin
                    if (i_flags.doc) begin
                        r_cnt[k] <= '0;
                    end else begin
                        r_cnt[k] <= n_cnt[k];
                    end
                end
            end
        end
        if (HASH_BITS < 64) begin : g_pad
            assign w_fp[63:HASH_BITS] = '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_flags.doc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.doc) begin
            r_out_fp <= w_fp;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fingerprint = r_out_fp;

endmodule

`default_nettype wire

// ----- src/simhash_fingerprint_djb2.sv -----
// m_axis_tvalid rises once a document end's request has passed through the queue
// and been taken into the back part's output register.
// Throughput: one request per cycle unless stalled; the hash update in the front part and the
// parallel counter update in the back part are each registered.
// The front stalls only when the four-entry queue is full (back held by m_axis).
// Reset (synchronous, active low) sets the hash to 5381 and all counters to zero.
`timescale 1ns / 1ps
`default_nettype none

module simhash_fingerprint_djb2
    import shfp_pkg::*;
#(
    parameter int HASH_BITS  = 64,
    parameter int COUNT_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] byte_valid, [1] token_end
    input  wire logic        s_axis_tlast,   // doc_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [63:0] fingerprint
);

    localparam int QW = HASH_BITS + FLAG_BITS;

    logic                 w_push;
    t_job_flags           w_push_flags;
    logic [HASH_BITS-1:0] w_push_hash;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_pop;
    logic [QW-1:0]        w_head;
    t_job_flags           w_head_flags;

    shfp_front #(
        .HASH_BITS (HASH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data_byte  (s_axis_tdata),
        .i_byte_valid (s_axis_tuser[0]),
        .i_token_end  (s_axis_tuser[1]),
        .i_doc_end    (s_axis_tlast),
        .o_push       (w_push),
        .o_push_flags (w_push_flags),
        .o_push_hash  (w_push_hash),
        .i_queue_full (w_full)
    );

    shfp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_flags, w_push_hash}),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_empty)
    );

    assign w_head_flags = t_job_flags'(w_head[QW-1:HASH_BITS]);

    shfp_back #(
        .HASH_BITS  (HASH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_flags       (w_head_flags),
        .i_hash        (w_head[HASH_BITS-1:0]),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_fingerprint (m_axis_tdata)
    );

endmodule

`default_nettype wire
